// File: design/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FSU_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fsu port check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FSU_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fsu port check failed");

`endif

// File: design/fsu_pkg.sv
// Types, codes and constants of the force layout update block.
package fsu_pkg;

    localparam int NODE_W = 12;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 17;
    localparam int OP_W   = 3;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_WRITE   = 3'd0;
    localparam op_t OP_ATTRACT = 3'd1;
    localparam op_t OP_REPEL   = 3'd2;
    localparam op_t OP_EPOCH   = 3'd3;
    localparam op_t OP_READ    = 3'd4;

    typedef struct packed {
        op_t                     op;
        logic [NODE_W-1:0]       node_a;
        logic [NODE_W-1:0]       node_b;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]       read_node;
        logic signed [POS_W-1:0] read_x;
        logic signed [POS_W-1:0] read_y;
    } rsp_t;

    // Register select (byte address bit 2)
    localparam logic REG_STEP_MIN   = 1'b0;
    localparam logic REG_STEP_DECAY = 1'b1;

    localparam logic [CFG_W-1:0] STEP_ONE       = 17'd65536;
    localparam logic [CFG_W-1:0] STEP_MAX       = 17'd131071;
    localparam logic [CFG_W-1:0] STEP_MIN_RST   = 17'd655;
    localparam logic [CFG_W-1:0] STEP_DECAY_RST = 17'd511;
    localparam logic [CFG_W-1:0] ATTR_BASE      = 17'd6554;

    // Dividends: 0.8 in Q0.16 scaled by 2^16, and 2^32
    localparam logic [32:0] ATTR_NUM  = 33'd3435986944;
    localparam logic [32:0] REPEL_NUM = 33'h1_0000_0000;

    // Shared unit width
    localparam int UW = 66;

    function automatic logic [POS_W-1:0] sat32(input logic signed [35:0] v);
        logic [POS_W-1:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/force_layout_sgd_update.sv
// Force layout SGD update engine: position store, shared add/shift unit, sequencer.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------
//  command   | start, busy (accept: start&!busy) | cmd   (fsu_pkg::cmd_t)
//  result    | done, one-cycle strobe        | result (fsu_pkg::rsp_t)
//  config    | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A command is accepted only while the block is idle. A write goes to the store at
// accept; a read passes S_RDU and S_OUT and its word strobes from the done register;
// epoch ends and updates run on the single 66-bit adder, which retires one multiplier
// bit or one quotient bit per cycle for every product and quotient.
// Reset puts the sequencer idle, drops done and loads the step size and config
// registers with reset values; payload registers and the position store are not
// reset. The receiver cannot stall: done lasts one cycle.
module force_layout_sgd_update #(
    parameter int MAX_NODES = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fsu_pkg::cmd_t   cmd,
    output logic            done,
    output fsu_pkg::rsp_t   result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import fsu_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [16:0] NODE_LIMIT = 17'(MAX_NODES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDU   = 4'd1;
    localparam logic [3:0] S_RDV   = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_SQX   = 4'd4;
    localparam logic [3:0] S_SQY   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_RSQ   = 4'd7;
    localparam logic [3:0] S_STEP  = 4'd8;
    localparam logic [3:0] S_MX    = 4'd9;
    localparam logic [3:0] S_MY    = 4'd10;
    localparam logic [3:0] S_WRU   = 4'd11;
    localparam logic [3:0] S_WRV   = 4'd12;
    localparam logic [3:0] S_EPOCH = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam logic [5:0] MUL_N = 6'd33;
    localparam logic [5:0] DIV_N = 6'd17;

    // Position store
    logic [POS_W-1:0] x_mem [MAX_NODES];
    logic [POS_W-1:0] y_mem [MAX_NODES];
    logic [POS_W-1:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en;
    logic [POS_W-1:0] wr_x, wr_y;

    // Sequencer and operands
    logic [3:0]       state_reg, state_next;
    op_t              op_reg, op_next;
    logic [AW-1:0]    u_reg, u_next, v_reg, v_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic             a_ok_reg, a_ok_next;
    logic [POS_W-1:0] xu_reg, xu_next, yu_reg, yu_next;
    logic [POS_W-1:0] xv_reg, xv_next, yv_reg, yv_next;
    logic             dx_neg_reg, dx_neg_next, dy_neg_reg, dy_neg_next;
    logic [32:0]      ax_reg, ax_next, ay_reg, ay_next;
    logic [49:0]      d2_reg, d2_next;
    logic [16:0]      c_reg, c_next;
    logic [33:0]      mxm_reg, mxm_next, mym_reg, mym_next;
    logic [16:0]      step_size_reg, step_size_next;
    logic [16:0]      step_min_reg, step_decay_reg;

    // Shared unit
    logic [UW-1:0]    acc_reg, acc_next, opa_reg, opa_next, opb_reg, opb_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             is_div;
    logic [UW-1:0]    add_b;
    logic [UW:0]      sum;

    logic             done_reg, done_next;
    rsp_t             result_reg, result_next;

    // Command decode
    logic             accept;
    logic [16:0]      a_ext, b_ext, other_ext;
    logic [12:0]      other;
    logic             a_ok, b_ok, other_ok;

    // Update arithmetic
    logic signed [32:0] dx_w, dy_w;
    logic [49:0]      den;
    logic [16:0]      q, l_att, diff_mag;
    logic [17:0]      delta;
    logic [18:0]      step_up;
    logic             sgn_x, sgn_y;
    logic signed [35:0] mx, my;
    logic [POS_W-1:0] new_xu, new_yu, new_xv, new_yv;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;

    assign a_ext     = {5'b0, cmd.node_a};
    assign b_ext     = {5'b0, cmd.node_b};
    assign other     = {1'b0, cmd.node_b} + {12'b0, (cmd.node_b >= cmd.node_a)};
    assign other_ext = {4'b0, other};
    assign a_ok      = a_ext < NODE_LIMIT;
    assign b_ok      = b_ext < NODE_LIMIT;
    assign other_ok  = other_ext < NODE_LIMIT;

    // One adder: add the shifted multiplicand, or trial-subtract the divisor
    assign is_div = (state_reg == S_DIV);
    assign add_b  = is_div ? ~opa_reg : opa_reg;
    assign sum    = {1'b0, acc_reg} + {1'b0, add_b} + {{UW{1'b0}}, is_div};

    assign dx_w = $signed({rd_x_reg[31], rd_x_reg}) - $signed({xu_reg[31], xu_reg});
    assign dy_w = $signed({rd_y_reg[31], rd_y_reg}) - $signed({yu_reg[31], yu_reg});

    assign den   = 50'd65536 + d2_reg + acc_reg[65:16];
    assign q     = opb_reg[16:0];
    assign l_att = ATTR_BASE + q;
    // Decay product can reach 18 bits when step_decay is above 1.0
    assign delta = acc_reg[33:16];
    assign step_up = {2'b0, step_size_reg} + {1'b0, delta};
    assign diff_mag = (step_min_reg < step_size_reg) ? (step_size_reg - step_min_reg)
                                                     : (step_min_reg - step_size_reg);

    // A repel move points away from the partner
    assign sgn_x = dx_neg_reg ^ (op_reg == OP_REPEL);
    assign sgn_y = dy_neg_reg ^ (op_reg == OP_REPEL);
    assign mx = sgn_x ? -$signed({2'b0, mxm_reg}) : $signed({2'b0, mxm_reg});
    assign my = sgn_y ? -$signed({2'b0, mym_reg}) : $signed({2'b0, mym_reg});
    assign new_xu = sat32($signed({{4{xu_reg[31]}}, xu_reg}) + mx);
    assign new_yu = sat32($signed({{4{yu_reg[31]}}, yu_reg}) + my);
    assign new_xv = sat32($signed({{4{xv_reg[31]}}, xv_reg}) - mx);
    assign new_yv = sat32($signed({{4{yv_reg[31]}}, yv_reg}) - my);

    // Store ports: read u, then v; write u, then v; direct writes at accept
    assign rd_addr = (state_reg == S_RDV) ? v_reg : u_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = u_reg;
        wr_x    = new_xu;
        wr_y    = new_yu;
        if (state_reg == S_WRU) begin
            wr_en = 1'b1;
        end else if (state_reg == S_WRV) begin
            wr_en   = 1'b1;
            wr_addr = v_reg;
            wr_x    = new_xv;
            wr_y    = new_yv;
        end else if (accept && cmd.op == OP_WRITE && a_ok) begin
            wr_en   = 1'b1;
            wr_addr = a_ext[AW-1:0];
            wr_x    = cmd.pos_x;
            wr_y    = cmd.pos_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        node_next      = node_reg;
        a_ok_next      = a_ok_reg;
        xu_next        = xu_reg;
        yu_next        = yu_reg;
        xv_next        = xv_reg;
        yv_next        = yv_reg;
        dx_neg_next    = dx_neg_reg;
        dy_neg_next    = dy_neg_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        d2_next        = d2_reg;
        c_next         = c_reg;
        mxm_next       = mxm_reg;
        mym_next       = mym_reg;
        step_size_next = step_size_reg;
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        if ((state_reg != S_IDLE) && (cnt_reg != 6'd0)) begin
            // Advance the shared unit by one bit
            cnt_next = cnt_reg - 6'd1;
            if (is_div) begin
                if (sum[UW]) begin
                    acc_next = sum[UW-1:0];
                end
                opb_next = {opb_reg[UW-2:0], sum[UW]};
                opa_next = opa_reg >> 1;
            end else begin
                if (opb_reg[0]) begin
                    acc_next = sum[UW-1:0];
                end
                opa_next = opa_reg << 1;
                opb_next = opb_reg >> 1;
            end
        end else begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        op_next   = cmd.op;
                        node_next = cmd.node_a;
                        a_ok_next = a_ok;
                        u_next    = a_ext[AW-1:0];
                        case (cmd.op)
                            OP_READ:
                            begin
                                state_next = S_RDU;
                            end
                            OP_ATTRACT:
                            begin
                                v_next = b_ext[AW-1:0];
                                if (a_ok && b_ok) begin
                                    state_next = S_RDU;
                                end
                            end
                            OP_REPEL:
                            begin
                                v_next = other_ext[AW-1:0];
                                if (a_ok && other_ok) begin
                                    state_next = S_RDU;
                                end
                            end
                            OP_EPOCH:
                            begin
                                dx_neg_next = step_min_reg < step_size_reg;
                                acc_next    = '0;
                                opa_next    = UW'(diff_mag);
                                opb_next    = UW'(step_decay_reg);
                                cnt_next    = MUL_N;
                                state_next  = S_EPOCH;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
                S_RDU:
                begin
                    state_next = (op_reg == OP_READ) ? S_OUT : S_RDV;
                end
                S_RDV:
                begin
                    xu_next    = rd_x_reg;
                    yu_next    = rd_y_reg;
                    state_next = S_DIFF;
                end
                S_DIFF:
                begin
                    xv_next     = rd_x_reg;
                    yv_next     = rd_y_reg;
                    dx_neg_next = dx_w[32];
                    dy_neg_next = dy_w[32];
                    ax_next     = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
                    ay_next     = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
                    acc_next    = '0;
                    opa_next    = dx_w[32] ? UW'(33'(-dx_w)) : UW'(33'(dx_w));
                    opb_next    = dx_w[32] ? UW'(33'(-dx_w)) : UW'(33'(dx_w));
                    cnt_next    = MUL_N;
                    state_next  = S_SQX;
                end
                S_SQX:
                begin
                    d2_next    = acc_reg[65:16];
                    acc_next   = '0;
                    opa_next   = UW'(ay_reg);
                    opb_next   = UW'(ay_reg);
                    cnt_next   = MUL_N;
                    state_next = S_SQY;
                end
                S_SQY:
                begin
                    // Hold the dividend in the accumulator, divisor aligned high
                    acc_next   = (op_reg == OP_REPEL) ? UW'(REPEL_NUM) : UW'(ATTR_NUM);
                    opa_next   = {den, 16'b0};
                    opb_next   = '0;
                    cnt_next   = DIV_N;
                    state_next = S_DIV;
                end
                S_DIV:
                begin
                    acc_next = '0;
                    cnt_next = MUL_N;
                    if (op_reg == OP_REPEL) begin
                        opa_next   = UW'(q);
                        opb_next   = UW'(q);
                        state_next = S_RSQ;
                    end else begin
                        opa_next   = UW'(step_size_reg);
                        opb_next   = UW'(l_att);
                        state_next = S_STEP;
                    end
                end
                S_RSQ:
                begin
                    acc_next   = '0;
                    opa_next   = UW'(step_size_reg);
                    opb_next   = UW'(acc_reg[32:16]);
                    cnt_next   = MUL_N;
                    state_next = S_STEP;
                end
                S_STEP:
                begin
                    c_next     = acc_reg[32:16];
                    acc_next   = '0;
                    opa_next   = UW'(acc_reg[32:16]);
                    opb_next   = UW'(ax_reg);
                    cnt_next   = MUL_N;
                    state_next = S_MX;
                end
                S_MX:
                begin
                    mxm_next   = acc_reg[49:16];
                    acc_next   = '0;
                    opa_next   = UW'(c_reg);
                    opb_next   = UW'(ay_reg);
                    cnt_next   = MUL_N;
                    state_next = S_MY;
                end
                S_MY:
                begin
                    mym_next   = acc_reg[49:16];
                    state_next = S_WRU;
                end
                S_WRU:
                begin
                    state_next = S_WRV;
                end
                S_WRV:
                begin
                    state_next = S_IDLE;
                end
                S_EPOCH:
                begin
                    if (dx_neg_reg) begin
                        step_size_next = ({1'b0, step_size_reg} >= delta)
                                         ? 17'({1'b0, step_size_reg} - delta) : 17'd0;
                    end else begin
                        step_size_next = (step_up[18:17] != 2'b00) ? STEP_MAX
                                                                    : step_up[16:0];
                    end
                    state_next = S_IDLE;
                end
                S_OUT:
                begin
                    done_next             = 1'b1;
                    result_next.read_node = node_reg;
                    result_next.read_x    = a_ok_reg ? rd_x_reg : '0;
                    result_next.read_y    = a_ok_reg ? rd_y_reg : '0;
                    state_next            = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            step_size_reg <= STEP_ONE;
            done_reg      <= 1'b0;
            cnt_reg       <= 6'd0;
        end else begin
            state_reg     <= state_next;
            step_size_reg <= step_size_next;
            done_reg      <= done_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        node_reg   <= node_next;
        a_ok_reg   <= a_ok_next;
        xu_reg     <= xu_next;
        yu_reg     <= yu_next;
        xv_reg     <= xv_next;
        yv_reg     <= yv_next;
        dx_neg_reg <= dx_neg_next;
        dy_neg_reg <= dy_neg_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        d2_reg     <= d2_next;
        c_reg      <= c_next;
        mxm_reg    <= mxm_next;
        mym_reg    <= mym_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        result_reg <= result_next;
    end

    // Configuration registers, selected by address bit 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_min_reg   <= STEP_MIN_RST;
            step_decay_reg <= STEP_DECAY_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_STEP_MIN) begin
                step_min_reg <= pwdata[16:0];
            end else begin
                step_decay_reg <= pwdata[16:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_STEP_DECAY) ? {15'b0, step_decay_reg}
                                                 : {15'b0, step_min_reg};

endmodule

// File: design/fsu_checker.sv
// Port-level checker for the force layout update block, with its bind.
`include "assert_macros.svh"

module fsu_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input fsu_pkg::cmd_t cmd,
    input logic          done
);
    import fsu_pkg::*;

    logic read_go;

    assign read_go = start && !busy && (cmd.op == OP_READ);

    `FSU_ASSERT_IMP(a_read_gives_word, read_go, ##3 done)
    `FSU_ASSERT_NXT(a_done_single, done, !done)
    `FSU_ASSERT_IMP(a_done_when_free, done, !busy)

endmodule

bind force_layout_sgd_update fsu_checker u_fsu_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the force layout SGD update block.
module tb;
    import fsu_pkg::*;

    localparam int NODES = 4096;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    rsp_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    force_layout_sgd_update #(.MAX_NODES(NODES)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // Shadow copy of the block's state, kept by the layout predictor.
    logic [31:0] x_shadow [NODES];
    logic [31:0] y_shadow [NODES];
    logic [16:0] step_now;
    logic [16:0] step_floor;
    logic [16:0] step_fall;

    rsp_t reads_due[$];
    int   mismatches;
    int   words_seen;
    int   items_sent;
    int   epochs_sent;
    int   updates_sent;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] sat_pos(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // One SGD pair update; partner loses what u gains.
    function automatic void move_pair(input int u, input int v, input bit repel);
        logic signed [63:0] dx, dy, mx, my;
        logic [63:0] ax, ay, d2, den, l, r, c;
        dx = 64'($signed(x_shadow[v])) - 64'($signed(x_shadow[u]));
        dy = 64'($signed(y_shadow[v])) - 64'($signed(y_shadow[u]));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2 = ((ax * ax) >> 16) + ((ay * ay) >> 16);
        den = 64'd65536 + d2;
        if (repel)
        begin
            r = (64'd1 << 32) / den;
            l = (r * r) >> 16;
        end
        else
        begin
            l = 64'd6554 + (64'd52429 * 64'd65536) / den;
        end
        c = (64'(step_now) * l) >> 16;
        mx = $signed((c * ax) >> 16);
        my = $signed((c * ay) >> 16);
        if ((dx < 0) != repel)
            mx = -mx;
        if ((dy < 0) != repel)
            my = -my;
        x_shadow[u] = 32'(sat_pos(64'($signed(x_shadow[u])) + mx));
        y_shadow[u] = 32'(sat_pos(64'($signed(y_shadow[u])) + my));
        x_shadow[v] = 32'(sat_pos(64'($signed(x_shadow[v])) - mx));
        y_shadow[v] = 32'(sat_pos(64'($signed(y_shadow[v])) - my));
    endfunction

    // Advance the shadow state by one accepted word; queue a read if any.
    function automatic void predict_layout(input cmd_t c);
        int a, b, s;
        logic signed [63:0] diff, delta, ns;
        rsp_t rd;
        a = c.node_a;
        b = c.node_b;
        case (c.op)
            OP_WRITE:
            begin
                x_shadow[a] = c.pos_x;
                y_shadow[a] = c.pos_y;
            end
            OP_ATTRACT:
                move_pair(a, b, 1'b0);
            OP_REPEL:
            begin
                s = b + (b >= a ? 1 : 0);
                if (s < NODES)
                    move_pair(a, s, 1'b1);
            end
            OP_EPOCH:
            begin
                diff = 64'(step_floor) - 64'(step_now);
                delta = ((diff < 0 ? -diff : diff) * 64'(step_fall)) >>> 16;
                if (diff < 0)
                    delta = -delta;
                ns = 64'(step_now) + delta;
                if (ns < 0)
                    ns = 0;
                if (ns > 131071)
                    ns = 131071;
                step_now = 17'(ns);
            end
            OP_READ:
            begin
                rd.read_node = c.node_a;
                rd.read_x = x_shadow[a];
                rd.read_y = y_shadow[a];
                reads_due.push_back(rd);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Compare each strobed read against the oldest expected one.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            words_seen++;
            if (reads_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected read word node=%0d", result.read_node);
            end
            else
            begin
                want = reads_due.pop_front();
                if (want !== result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read mismatch: exp %0d %h %h got %0d %h %h",
                            want.read_node, want.read_x, want.read_y,
                            result.read_node, result.read_x, result.read_y);
                end
            end
        end
    end

    // Idle gaps between bursts, drawn fresh each burst.
    int burst_left;

    // Drive one word: hold start until the block takes it.
    task automatic send_cmd(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_layout(c);
        items_sent++;
        if (c.op == OP_EPOCH)
            epochs_sent++;
        if (c.op == OP_ATTRACT || c.op == OP_REPEL)
            updates_sent++;
    endtask

    // Let the block drain: all reads back, then cover the longest update.
    task automatic drain;
        start <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [16:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (addr[2] == REG_STEP_DECAY)
            step_fall = val;
        else
            step_floor = val;
    endtask

    function automatic cmd_t make_cmd(input op_t op, input int a, input int b,
                                      input logic [31:0] x, input logic [31:0] y);
        cmd_t c;
        c.op = op;
        c.node_a = 12'(a);
        c.node_b = 12'(b);
        c.pos_x = x;
        c.pos_y = y;
        return c;
    endfunction

    // Random node from a small working pool, so updates hit written entries.
    function automatic int pick_node();
        int n;
        n = $urandom_range(0, 15);
        if (n < 12)
            return n;
        return NODES - 1 - (n - 12);
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // Directed rows; an expected read is typed in where obvious.
    typedef struct {
        cmd_t        c;
        bit          known;
        logic [31:0] ex;
        logic [31:0] ey;
    } row_t;

    row_t rows[$];

    task automatic add_row(input cmd_t c, input bit known,
                           input logic [31:0] ex, input logic [31:0] ey);
        row_t r;
        r.c = c;
        r.known = known;
        r.ex = ex;
        r.ey = ey;
        rows.push_back(r);
    endtask

    initial
    begin
        cmd_t c;
        int op_pick;
        int n;
        logic [16:0] cfg_sets [6][2];

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        words_seen = 0;
        items_sent = 0;
        epochs_sent = 0;
        updates_sent = 0;
        burst_left = 0;
        step_now = STEP_ONE;
        step_floor = STEP_MIN_RST;
        step_fall = STEP_DECAY_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of position, node ids, every op, and the corner cases.
        add_row(make_cmd(OP_WRITE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000), 0, 0, 0);
        add_row(make_cmd(OP_READ, 0, 0, 0, 0), 1, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(make_cmd(OP_WRITE, 4095, 0, 32'h8000_0000, 32'h7FFF_FFFF), 0, 0, 0);
        add_row(make_cmd(OP_READ, 4095, 0, 0, 0), 1, 32'h8000_0000, 32'h7FFF_FFFF);
        add_row(make_cmd(OP_WRITE, 1, 0, 32'h0001_0000, 32'hFFFF_0000), 0, 0, 0);
        add_row(make_cmd(OP_WRITE, 2, 0, 32'h0000_0000, 32'h0000_0000), 0, 0, 0);
        // Attract between both extreme nodes.
        add_row(make_cmd(OP_ATTRACT, 0, 4095, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 4095, 0, 0, 0), 0, 0, 0);
        // Same node on attract moves nothing.
        add_row(make_cmd(OP_ATTRACT, 1, 1, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 1, 0, 0, 0), 1, 32'h0001_0000, 32'hFFFF_0000);
        add_row(make_cmd(OP_ATTRACT, 1, 2, 0, 0), 0, 0, 0);
        // Repel: draw below u, draw at u (skips past it), draw too large.
        add_row(make_cmd(OP_REPEL, 2, 1, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_REPEL, 1, 1, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_REPEL, 0, 4095, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_REPEL, 1, 4094, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 1, 0, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 2, 0, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_EPOCH, 0, 0, 0, 0), 0, 0, 0);
        // Unused op codes are dropped with no word back.
        add_row(make_cmd(3'd5, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_cmd(3'd6, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, 0, 0);
        add_row(make_cmd(3'd7, 0, 0, 0, 0), 0, 0, 0);
        add_row(make_cmd(OP_READ, 0, 0, 0, 0), 0, 0, 0);

        foreach (rows[i])
        begin
            send_cmd(rows[i].c);
            // Override the predictor's word with the typed-in value when given.
            if (rows[i].known)
            begin
                reads_due[$].read_x = rows[i].ex;
                reads_due[$].read_y = rows[i].ey;
            end
        end
        drain();

        // Config phases: zero, 65536, mixed values and the reset values, both registers each time.
        cfg_sets[0] = '{17'd0, 17'd0};
        cfg_sets[1] = '{17'd65536, 17'd65536};
        cfg_sets[2] = '{17'd0, 17'd65536};
        cfg_sets[3] = '{17'd65536, 17'd32768};
        cfg_sets[4] = '{17'd1000, 17'd4000};
        cfg_sets[5] = '{STEP_MIN_RST, STEP_DECAY_RST};

        // Seed the working pool so every random read hits a written entry.
        for (int i = 0; i < 16; i++)
            send_cmd(make_cmd(OP_WRITE, i < 12 ? i : NODES - 1 - (i - 12), 0,
                              pick_pos(), pick_pos()));
        // A repel draw of 11 skips past u onto node 12.
        send_cmd(make_cmd(OP_WRITE, 12, 0, pick_pos(), pick_pos()));

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_reg({REG_STEP_MIN, 2'b00}, cfg_sets[p][0]);
            write_reg({REG_STEP_DECAY, 2'b00}, cfg_sets[p][1]);
            for (int k = 0; k < 100; k++)
            begin
                op_pick = $urandom_range(0, 99);
                n = pick_node();
                if (op_pick < 15)
                    c = make_cmd(OP_WRITE, n, $urandom(), pick_pos(), pick_pos());
                else if (op_pick < 40)
                    c = make_cmd(OP_ATTRACT, n, pick_node(), $urandom(), $urandom());
                else if (op_pick < 55)
                    c = make_cmd(OP_REPEL, n,
                                 $urandom_range(0, 9) == 0 ? $urandom_range(4094, 4095)
                                                          : pick_node(),
                                 $urandom(), $urandom());
                else if (op_pick < 65)
                    c = make_cmd(OP_EPOCH, $urandom(), $urandom(), $urandom(), $urandom());
                else if (op_pick < 95)
                    c = make_cmd(OP_READ, n, $urandom(), $urandom(), $urandom());
                else
                    c = make_cmd(op_t'($urandom_range(5, 7)), $urandom(), $urandom(),
                                 $urandom(), $urandom());
                send_cmd(c);
            end
        end
        drain();

        $display("covered %0d words (%0d updates, %0d epoch ends), %0d reads checked",
                 items_sent, updates_sent, epochs_sent, words_seen);
        $display("six step_min/step_decay settings including both extremes");
        if (mismatches == 0 && reads_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog for the slowest run, about 650 words with gaps; give it headroom.
    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
